// File: rtl/cor_pkg.sv
// ----------------------------------------------------------------------------
// cor_pkg: shared types and constants of the circle outline rasterizer
// Field widths, result kind codes, the controller state type and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package cor_pkg;

	localparam int CENTER_W = 12;
	localparam int RAD_W    = 8;
	localparam int COORD_W  = 13;
	localparam int OFF_W    = 7;
	localparam int DEC_W    = 11;

	localparam int DEF_MAX_RADIUS = 64;

	localparam int IN_DATA_W  = 2 * CENTER_W + RAD_W;
	localparam int OUT_DATA_W = 8 * COORD_W;

	localparam logic [DEC_W-1:0] DEC_THREE = DEC_W'(3);
	localparam logic [DEC_W-1:0] DEC_TWO   = DEC_W'(2);

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_POINT = 2'd1,
		KIND_OCT   = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_ARC
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic final_res;
	} dp_status_t;

endpackage

// File: rtl/cor_ctrl.sv
// ----------------------------------------------------------------------------
// cor_ctrl: circle sequencing controller
// Takes one circle request, then orders one result per step until the
// datapath reports the final result of the circle.
// ----------------------------------------------------------------------------
module cor_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  cor_pkg::dp_status_t status,
	output cor_pkg::dp_cmd_t    cmd
);
	import cor_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = ST_ARC;
				end
			end
			ST_ARC: begin
				if (status.out_free && status.final_res) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_ARC: begin
				cmd.emit = status.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/cor_datapath.sv
// ----------------------------------------------------------------------------
// cor_datapath: midpoint circle datapath
// Holds the centre, both offsets and the decision term, forms the eight
// symmetric coordinates and keeps the result in an output register.
// ----------------------------------------------------------------------------
module cor_datapath #(
	parameter int MAX_RADIUS = cor_pkg::DEF_MAX_RADIUS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cor_pkg::dp_cmd_t                    cmd,
	output cor_pkg::dp_status_t                 status,
	input  logic signed [cor_pkg::CENTER_W-1:0] center_x,
	input  logic signed [cor_pkg::CENTER_W-1:0] center_y,
	input  logic signed [cor_pkg::RAD_W-1:0]    radius,
	input  logic                                out_ready,
	output logic                                out_valid,
	output cor_pkg::kind_t                      kind,
	output logic signed [cor_pkg::COORD_W-1:0]  x_plus_far,
	output logic signed [cor_pkg::COORD_W-1:0]  x_minus_far,
	output logic signed [cor_pkg::COORD_W-1:0]  x_plus_near,
	output logic signed [cor_pkg::COORD_W-1:0]  x_minus_near,
	output logic signed [cor_pkg::COORD_W-1:0]  y_plus_near,
	output logic signed [cor_pkg::COORD_W-1:0]  y_minus_near,
	output logic signed [cor_pkg::COORD_W-1:0]  y_plus_far,
	output logic signed [cor_pkg::COORD_W-1:0]  y_minus_far,
	output logic                                last
);
	import cor_pkg::*;

	localparam logic [RAD_W-1:0] RAD_LIMIT = RAD_W'(MAX_RADIUS);

	// Circle state.
	logic [CENTER_W-1:0] cx_q;
	logic [CENTER_W-1:0] cy_q;
	logic [OFF_W-1:0]    long_q;
	logic [OFF_W-1:0]    short_q;
	logic [DEC_W-1:0]    dec_q;
	kind_t               kind_q;

	// Output register.
	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [COORD_W-1:0]  xpf_q, xmf_q, xpn_q, xmn_q;
	logic [COORD_W-1:0]  ypn_q, ymn_q, ypf_q, ymf_q;
	logic                out_last_q;

	logic [RAD_W-1:0]    rad_mag;
	logic [OFF_W-1:0]    rad_sat;
	logic [DEC_W-1:0]    dec_init;
	kind_t               kind_init;

	logic [OFF_W-1:0]    short_inc;
	logic [OFF_W-1:0]    long_dec;
	logic [DEC_W-1:0]    short4;
	logic [DEC_W-1:0]    long4;
	logic                dec_neg;
	logic [OFF_W-1:0]    long_nxt;
	logic [DEC_W-1:0]    dec_nxt;
	logic                run_done;

	logic [COORD_W-1:0]  cx_ext, cy_ext, long_ext, short_ext;
	logic [COORD_W-1:0]  xpf_d, xmf_d, xpn_d, xmn_d;
	logic [COORD_W-1:0]  ypn_d, ymn_d, ypf_d, ymf_d;

	// Radius magnitude, clipped to the largest supported radius.
	always_comb begin
		rad_mag = radius[RAD_W-1] ? (~radius + RAD_W'(1)) : radius;
		if (rad_mag > RAD_LIMIT) begin
			rad_sat = RAD_LIMIT[OFF_W-1:0];
		end else begin
			rad_sat = rad_mag[OFF_W-1:0];
		end
		dec_init = DEC_THREE - {{(DEC_W-OFF_W-1){1'b0}}, rad_sat, 1'b0};
		if (rad_sat == '0) begin
			kind_init = KIND_NONE;
		end else if (rad_sat == OFF_W'(1)) begin
			kind_init = KIND_POINT;
		end else begin
			kind_init = KIND_OCT;
		end
	end

	// One midpoint step; both update forms use the stepped offsets.
	always_comb begin
		short_inc = short_q + OFF_W'(1);
		long_dec  = long_q - OFF_W'(1);
		short4    = {{(DEC_W-OFF_W-2){1'b0}}, short_inc, 2'b00};
		long4     = {{(DEC_W-OFF_W-2){1'b0}}, long_dec, 2'b00};
		dec_neg   = dec_q[DEC_W-1];
		if (dec_neg) begin
			long_nxt = long_q;
			dec_nxt  = dec_q + short4 + DEC_TWO;
		end else begin
			long_nxt = long_dec;
			dec_nxt  = dec_q + short4 - long4 + DEC_TWO;
		end
		run_done = long_nxt < short_inc;
	end

	// Coordinates of the current step.
	always_comb begin
		cx_ext    = {cx_q[CENTER_W-1], cx_q};
		cy_ext    = {cy_q[CENTER_W-1], cy_q};
		long_ext  = {{(COORD_W-OFF_W){1'b0}}, long_q};
		short_ext = {{(COORD_W-OFF_W){1'b0}}, short_q};
		xpf_d = '0;
		xmf_d = '0;
		xpn_d = '0;
		xmn_d = '0;
		ypn_d = '0;
		ymn_d = '0;
		ypf_d = '0;
		ymf_d = '0;
		case (kind_q)
			KIND_POINT: begin
				xpf_d = cx_ext;
				ypn_d = cy_ext;
			end
			KIND_OCT: begin
				xpf_d = cx_ext + long_ext;
				xmf_d = cx_ext - long_ext;
				xpn_d = cx_ext + short_ext;
				xmn_d = cx_ext - short_ext;
				ypn_d = cy_ext + short_ext;
				ymn_d = cy_ext - short_ext;
				ypf_d = cy_ext + long_ext;
				ymf_d = cy_ext - long_ext;
			end
			default: begin
				xpf_d = '0;
			end
		endcase
	end

	assign status.out_free  = !out_valid_q || out_ready;
	assign status.final_res = (kind_q != KIND_OCT) || run_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
		end else if (cmd.load) begin
			kind_q <= kind_init;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			long_q  <= rad_sat;
			short_q <= '0;
			dec_q   <= dec_init;
		end else if (cmd.emit) begin
			short_q <= short_inc;
			long_q  <= long_nxt;
			dec_q   <= dec_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= kind_q;
			xpf_q      <= xpf_d;
			xmf_q      <= xmf_d;
			xpn_q      <= xpn_d;
			xmn_q      <= xmn_d;
			ypn_q      <= ypn_d;
			ymn_q      <= ymn_d;
			ypf_q      <= ypf_d;
			ymf_q      <= ymf_d;
			out_last_q <= status.final_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_kind_q;
	assign x_plus_far   = xpf_q;
	assign x_minus_far  = xmf_q;
	assign x_plus_near  = xpn_q;
	assign x_minus_near = xmn_q;
	assign y_plus_near  = ypn_q;
	assign y_minus_near = ymn_q;
	assign y_plus_far   = ypf_q;
	assign y_minus_far  = ymf_q;
	assign last         = out_last_q;

endmodule

// File: rtl/circle_outline_rasterizer_top.sv
// ----------------------------------------------------------------------------
// circle_outline_rasterizer_top: midpoint circle outline generator
// Turns a centre and a signed radius into the stream of eight-way symmetric
// outline points of the midpoint circle method.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Carries
// s_*       in   one circle request: centre and signed radius
// m_*       out  one result per midpoint step: kind, eight coordinates, last
//
// A request is taken while the controller is idle; the next cycle starts
// the walk. Each midpoint step then loads one result into the output
// register per cycle while the output register is free. A stalled output
// holds the walk in place without loss; a new request is taken the cycle
// after the final result is registered, even while that result still
// waits to be taken. Reset returns the controller to idle and empties the
// output register.
//
module circle_outline_rasterizer_top #(
	parameter int MAX_RADIUS = cor_pkg::DEF_MAX_RADIUS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// center_x[11:0], center_y[23:12], radius[31:24]
	input  logic [cor_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// x_plus_far, x_minus_far, x_plus_near, x_minus_near, y_plus_near,
	// y_minus_near, y_plus_far, y_minus_far; 13 bits each from bit 0 up
	output logic [cor_pkg::OUT_DATA_W-1:0]   m_tdata,
	// kind[1:0]
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready
);
	import cor_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	kind_t      kind;

	logic signed [CENTER_W-1:0] center_x;
	logic signed [CENTER_W-1:0] center_y;
	logic signed [RAD_W-1:0]    radius;

	logic [COORD_W-1:0] x_plus_far, x_minus_far, x_plus_near, x_minus_near;
	logic [COORD_W-1:0] y_plus_near, y_minus_near, y_plus_far, y_minus_far;

	// Unpack the request; the centre sits in the low bits.
	assign center_x = s_tdata[CENTER_W-1:0];
	assign center_y = s_tdata[2*CENTER_W-1:CENTER_W];
	assign radius   = s_tdata[2*CENTER_W+RAD_W-1:2*CENTER_W];

	cor_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cor_datapath #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius       (radius),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.kind         (kind),
		.x_plus_far   (x_plus_far),
		.x_minus_far  (x_minus_far),
		.x_plus_near  (x_plus_near),
		.x_minus_near (x_minus_near),
		.y_plus_near  (y_plus_near),
		.y_minus_near (y_minus_near),
		.y_plus_far   (y_plus_far),
		.y_minus_far  (y_minus_far),
		.last         (m_tlast)
	);

	// The eight coordinates fill exactly thirteen bytes, so no padding.
	assign m_tdata = {y_minus_far, y_plus_far, y_minus_near, y_plus_near,
	                  x_minus_near, x_plus_near, x_minus_far, x_plus_far};
	assign m_tuser = kind;

	// Only one circle is walked at a time: a taken request closes the input.
	a_one_circle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while a circle is in progress");

	// Zero and unit radius produce a single result, which must be the last.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (kind == KIND_NONE || kind == KIND_POINT)) |-> m_tlast)
		else $error("single result of a degenerate circle is not last");

	// An empty result carries no coordinates.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && kind == KIND_NONE) |-> (m_tdata == '0))
		else $error("empty result carries coordinates");

	// Every emitted step keeps the long offset at or above the short one.
	a_octant: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && kind == KIND_OCT) |->
		($signed(x_plus_far) >= $signed(x_plus_near)))
		else $error("long offset fell below short offset in a result");

endmodule
